### hdl/bmh_pkg.sv
`default_nettype none

package bmh_pkg;

    localparam int CAPACITY = 1024;
    localparam int DATA_W = 32;
    localparam int ADDR_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int IDX_W = ADDR_W + 2;
    localparam int ENTRY_COUNT_W = 11;
    localparam logic [CNT_W-1:0] CAP_CNT = CNT_W'(CAPACITY);

    localparam int QDEPTH = 2;
    localparam int QPTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    localparam logic OP_INSERT = 1'b0;
    localparam logic OP_EXTRACT = 1'b1;

    localparam logic [1:0] STATUS_DONE = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_EMPTY = 2'd2;

    localparam logic [1:0] KIND_INSERT = 2'd0;
    localparam logic [1:0] KIND_EXTRACT = 2'd1;
    localparam logic [1:0] KIND_REJ_FULL = 2'd2;
    localparam logic [1:0] KIND_REJ_EMPTY = 2'd3;

    typedef struct packed {
        logic               op;
        logic signed [31:0] value;
    } in_word_t;

    typedef struct packed {
        logic signed [31:0]        min_value;
        logic [ENTRY_COUNT_W-1:0]  entry_count;
        logic                      is_empty;
        logic [1:0]                status;
    } out_word_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] value;
    } cmd_t;

endpackage

`default_nettype wire

### hdl/bmh_front.sv
`default_nettype none

module bmh_front (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_valid,
    output logic                  s_ready,
    input  wire bmh_pkg::in_word_t s_word,
    output logic                  push_valid,
    input  wire logic             push_ready,
    output bmh_pkg::cmd_t         push_cmd
);

    logic [bmh_pkg::CNT_W-1:0] cnt_reg, cnt_next;
    logic                      accept;

    assign s_ready = push_ready;
    assign push_valid = s_valid;
    assign accept = s_valid && push_ready;

    // Classify against the count the heap will hold once earlier words are done
    always_comb begin
        cnt_next = cnt_reg;
        push_cmd.value = s_word.value;
        if (s_word.op == bmh_pkg::OP_INSERT) begin
            if (cnt_reg == bmh_pkg::CAP_CNT) begin
                push_cmd.kind = bmh_pkg::KIND_REJ_FULL;
            end else begin
                push_cmd.kind = bmh_pkg::KIND_INSERT;
                cnt_next = cnt_reg + 1'b1;
            end
        end else begin
            if (cnt_reg == '0) begin
                push_cmd.kind = bmh_pkg::KIND_REJ_EMPTY;
            end else begin
                push_cmd.kind = bmh_pkg::KIND_EXTRACT;
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg <= '0;
        end else if (accept) begin
            cnt_reg <= cnt_next;
        end
    end

endmodule

`default_nettype wire

### hdl/bmh_queue.sv
`default_nettype none

module bmh_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          wr_valid,
    output logic               wr_ready,
    input  wire bmh_pkg::cmd_t wr_cmd,
    output logic               rd_valid,
    input  wire logic          rd_ready,
    output bmh_pkg::cmd_t      rd_cmd
);

    bmh_pkg::cmd_t                slot_reg [bmh_pkg::QDEPTH];
    logic [bmh_pkg::QPTR_W-1:0]   wptr_reg, rptr_reg;
    logic [bmh_pkg::QCNT_W-1:0]   cnt_reg;
    logic                         push, pop;

    assign wr_ready = (cnt_reg != bmh_pkg::QCNT_W'(bmh_pkg::QDEPTH));
    assign rd_valid = (cnt_reg != '0);
    assign rd_cmd = slot_reg[rptr_reg];
    assign push = wr_valid && wr_ready;
    assign pop = rd_valid && rd_ready;

    always_ff @(posedge aclk) begin
        if (push) begin
            slot_reg[wptr_reg] <= wr_cmd;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg <= '0;
            rptr_reg <= '0;
            cnt_reg <= '0;
        end else begin
            if (push) begin
                wptr_reg <= (wptr_reg == bmh_pkg::QPTR_W'(bmh_pkg::QDEPTH - 1)) ?
                            '0 : wptr_reg + 1'b1;
            end
            if (pop) begin
                rptr_reg <= (rptr_reg == bmh_pkg::QPTR_W'(bmh_pkg::QDEPTH - 1)) ?
                            '0 : rptr_reg + 1'b1;
            end
            if (push && !pop) begin
                cnt_reg <= cnt_reg + 1'b1;
            end else if (pop && !push) begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

endmodule

`default_nettype wire

### hdl/bmh_engine.sv
`default_nettype none

module bmh_engine (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              cmd_valid,
    output logic                   cmd_ready,
    input  wire bmh_pkg::cmd_t     cmd,
    output logic                   m_valid,
    input  wire logic              m_ready,
    output bmh_pkg::out_word_t     m_word
);

    localparam logic [3:0] ST_IDLE    = 4'd0;
    localparam logic [3:0] ST_UP_RD   = 4'd1;
    localparam logic [3:0] ST_UP_CMP  = 4'd2;
    localparam logic [3:0] ST_LAST_WT = 4'd3;
    localparam logic [3:0] ST_DN_RL   = 4'd4;
    localparam logic [3:0] ST_DN_RR   = 4'd5;
    localparam logic [3:0] ST_DN_CMP  = 4'd6;
    localparam logic [3:0] ST_FIN     = 4'd7;

    logic [3:0]                  state_reg, state_next;
    logic [bmh_pkg::ADDR_W-1:0]  pos_reg, pos_next;
    logic [bmh_pkg::ADDR_W-1:0]  par_reg, par_next;
    logic signed [31:0]          val_reg, val_next;
    logic signed [31:0]          lval_reg, lval_next;
    logic                        rvld_reg, rvld_next;
    logic [bmh_pkg::CNT_W-1:0]   cnt_reg, cnt_next;
    logic [1:0]                  status_reg, status_next;
    logic signed [31:0]          root_reg;
    bmh_pkg::out_word_t          out_reg;
    logic                        out_valid_reg;

    logic signed [31:0]          heap_mem [bmh_pkg::CAPACITY];
    logic signed [31:0]          rdata_reg;
    logic                        we, re;
    logic [bmh_pkg::ADDR_W-1:0]  waddr, raddr;
    logic signed [31:0]          wdata;

    logic [bmh_pkg::CNT_W-1:0]   cnt_dec;
    logic [bmh_pkg::IDX_W-1:0]   left_idx, right_idx, cnt_idx;
    logic                        pick_right;
    logic signed [31:0]          pick_val;
    logic [bmh_pkg::CNT_W+bmh_pkg::ENTRY_COUNT_W-1:0] cnt_wide;
    logic                        out_free;

    assign cnt_dec = cnt_reg - 1'b1;
    assign left_idx = {{(bmh_pkg::IDX_W-bmh_pkg::ADDR_W-1){1'b0}}, pos_reg, 1'b1};
    assign right_idx = left_idx + 1'b1;
    assign cnt_idx = {{(bmh_pkg::IDX_W-bmh_pkg::CNT_W){1'b0}}, cnt_reg};
    assign pick_right = rvld_reg && (rdata_reg < lval_reg);
    assign pick_val = pick_right ? rdata_reg : lval_reg;
    assign cnt_wide = {{bmh_pkg::ENTRY_COUNT_W{1'b0}}, cnt_reg};
    assign out_free = !out_valid_reg || m_ready;
    assign cmd_ready = (state_reg == ST_IDLE);
    assign m_valid = out_valid_reg;
    assign m_word = out_reg;

    // Sift with a moving hole: shifted entries are written once, the carried value last
    always_comb begin
        state_next = state_reg;
        pos_next = pos_reg;
        par_next = par_reg;
        val_next = val_reg;
        lval_next = lval_reg;
        rvld_next = rvld_reg;
        cnt_next = cnt_reg;
        status_next = status_reg;
        we = 1'b0;
        waddr = pos_reg;
        wdata = val_reg;
        re = 1'b0;
        raddr = '0;
        case (state_reg)
            ST_IDLE: begin
                if (cmd_valid) begin
                    status_next = bmh_pkg::STATUS_DONE;
                    case (cmd.kind)
                        bmh_pkg::KIND_INSERT: begin
                            val_next = cmd.value;
                            pos_next = cnt_reg[bmh_pkg::ADDR_W-1:0];
                            cnt_next = cnt_reg + 1'b1;
                            state_next = ST_UP_RD;
                        end
                        bmh_pkg::KIND_EXTRACT: begin
                            cnt_next = cnt_dec;
                            pos_next = '0;
                            if (cnt_dec == '0) begin
                                state_next = ST_FIN;
                            end else begin
                                re = 1'b1;
                                raddr = cnt_dec[bmh_pkg::ADDR_W-1:0];
                                state_next = ST_LAST_WT;
                            end
                        end
                        bmh_pkg::KIND_REJ_FULL: begin
                            status_next = bmh_pkg::STATUS_FULL;
                            state_next = ST_FIN;
                        end
                        default: begin
                            status_next = bmh_pkg::STATUS_EMPTY;
                            state_next = ST_FIN;
                        end
                    endcase
                end
            end
            ST_UP_RD: begin
                if (pos_reg == '0) begin
                    we = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    re = 1'b1;
                    raddr = (pos_reg - 1'b1) >> 1;
                    par_next = raddr;
                    state_next = ST_UP_CMP;
                end
            end
            ST_UP_CMP: begin
                we = 1'b1;
                if (val_reg < rdata_reg) begin
                    wdata = rdata_reg;
                    pos_next = par_reg;
                    state_next = ST_UP_RD;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_LAST_WT: begin
                val_next = rdata_reg;
                state_next = ST_DN_RL;
            end
            ST_DN_RL: begin
                if (left_idx >= cnt_idx) begin
                    we = 1'b1;
                    state_next = ST_FIN;
                end else begin
                    re = 1'b1;
                    raddr = left_idx[bmh_pkg::ADDR_W-1:0];
                    state_next = ST_DN_RR;
                end
            end
            ST_DN_RR: begin
                lval_next = rdata_reg;
                rvld_next = (right_idx < cnt_idx);
                if (right_idx < cnt_idx) begin
                    re = 1'b1;
                    raddr = right_idx[bmh_pkg::ADDR_W-1:0];
                end
                state_next = ST_DN_CMP;
            end
            ST_DN_CMP: begin
                we = 1'b1;
                if (pick_val < val_reg) begin
                    wdata = pick_val;
                    pos_next = pick_right ? right_idx[bmh_pkg::ADDR_W-1:0] :
                                            left_idx[bmh_pkg::ADDR_W-1:0];
                    state_next = ST_DN_RL;
                end else begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN: begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (we) begin
            heap_mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= heap_mem[raddr];
        end
    end

    always_ff @(posedge aclk) begin
        pos_reg <= pos_next;
        par_reg <= par_next;
        val_reg <= val_next;
        lval_reg <= lval_next;
        rvld_reg <= rvld_next;
        status_reg <= status_next;
        // keep a copy of the root so the minimum needs no read
        if (we && waddr == '0) begin
            root_reg <= wdata;
        end
        if (state_reg == ST_FIN && out_free) begin
            out_reg.min_value <= (cnt_reg == '0) ? '0 : root_reg;
            out_reg.entry_count <= cnt_wide[bmh_pkg::ENTRY_COUNT_W-1:0];
            out_reg.is_empty <= (cnt_reg == '0);
            out_reg.status <= status_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
            cnt_reg <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            cnt_reg <= cnt_next;
            if (state_reg == ST_FIN && out_free) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= bmh_pkg::CAP_CNT)
        else $error("heap count beyond capacity");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_UP_CMP |-> pos_reg != '0)
        else $error("sift-up compare at the root");

    assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_DN_RL || state_reg == ST_DN_CMP) |->
        {{(bmh_pkg::IDX_W-bmh_pkg::ADDR_W){1'b0}}, pos_reg} < cnt_idx)
        else $error("sift-down hole outside the heap");

    assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == ST_FIN && status_reg == bmh_pkg::STATUS_EMPTY |-> cnt_reg == '0)
        else $error("extract rejected on a nonempty heap");

    assert property (@(posedge aclk) disable iff (!aresetn)
        out_valid_reg && !m_ready |=> out_valid_reg && $stable(out_reg))
        else $error("result word dropped under stall");

endmodule

`default_nettype wire

### hdl/binary_min_heap_top.sv
`default_nettype none

// Min-heap priority queue of signed 32-bit values, up to bmh_pkg::CAPACITY entries.
// Input channel s_*: each word is an insert (op 0, value) or an extract-minimum (op 1).
// Result channel m_*: exactly one word per input word, in order, giving the minimum
// after the operation (zero when empty), the entry count, an empty flag and a status
// (done, insert rejected full, extract rejected empty).
// A front stage classifies words against the count they will see and queues them two
// deep; the heap engine works on one word at a time with a single-port heap memory.
// An insert climbs from the new last slot, reading each parent and moving it down
// while it is larger than the new value; an extract takes the last entry and carries
// it down from the root, reading the left and then the right child and moving the
// smaller up while it is below the carried value; rejected words and the extract that
// empties the heap go straight to the result. The engine takes the next word only once
// its result is in the output register; the one read port reads the children in turn.
// The result sits in an output register: the engine finishes its current word while
// the receiver stalls and waits only to hand over the next result; the queue keeps
// accepting until it is full.
// Reset empties the heap and the queue and drops any pending result.

module binary_min_heap_top (
    input  wire logic                aclk,
    input  wire logic                aresetn,
    input  wire logic                s_valid,
    output logic                     s_ready,
    input  wire bmh_pkg::in_word_t   s_word,
    output logic                     m_valid,
    input  wire logic                m_ready,
    output bmh_pkg::out_word_t       m_word
);

    logic          push_valid, push_ready;
    bmh_pkg::cmd_t push_cmd;
    logic          cmd_valid, cmd_ready;
    bmh_pkg::cmd_t cmd;

    bmh_front u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_word     (s_word),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_cmd   (push_cmd)
    );

    bmh_queue u_queue (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .wr_valid (push_valid),
        .wr_ready (push_ready),
        .wr_cmd   (push_cmd),
        .rd_valid (cmd_valid),
        .rd_ready (cmd_ready),
        .rd_cmd   (cmd)
    );

    bmh_engine u_engine (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_word    (m_word)
    );

endmodule

`default_nettype wire
